// File: design/cgos_pkg.sv
// types, constants and helpers shared by the orbit step block
// no dependencies

package cgos_pkg;

    localparam int S_TDATA_W = 216;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 192;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DT_W = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_GM     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TSCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RMIN   = 2'd2;

    localparam logic [31:0] GM_RESET     = 32'd65536000;
    localparam logic [15:0] TSCALE_RESET = 16'd256;
    localparam logic [30:0] RMIN_RESET   = 31'd655360;

    localparam logic [46:0] TERM_CAP = 47'h4000_0000_0000;

    typedef struct packed {
        logic [31:0] gm;
        logic [15:0] tscale;
        logic [30:0] rmin;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
        logic [DT_W-1:0]  dt;
        logic             act;
    } t_item;

    typedef struct packed {
        t_item            item;
        logic [2:0][63:0] sq;
    } t_qent;

    typedef struct packed {
        t_item       item;
        logic [31:0] r;
        logic        sat;
    } t_bk;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? 32'(~x + 32'd1) : x;
    endfunction

    function automatic logic signed [48:0] smag(input logic neg, input logic [46:0] m);
        logic signed [48:0] s;
        s = $signed({2'b00, m});
        return neg ? -s : s;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [48:0] x);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sd2147483647;
        lo = -49'sd2147483648;
        if (x > hi) begin
            return 32'h7fff_ffff;
        end else if (x < lo) begin
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

endpackage

// File: design/cgos_front.sv
// front end: unpacks a request, forms the time step and the squared coordinates
// depends on cgos_pkg

module cgos_front (
    input  logic [cgos_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [cgos_pkg::S_TUSER_W-1:0] i_tuser,
    input  logic [15:0]                    i_tscale,
    output cgos_pkg::t_qent                o_entry
);
    import cgos_pkg::*;

    logic [19:0] w_ft;
    logic [35:0] w_dtp;
    logic [2:0][31:0] w_pm;

    assign w_ft  = i_tdata[211:192];
    assign w_dtp = {16'd0, w_ft} * {20'd0, i_tscale};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_entry.item.p[i] = i_tdata[32*i +: 32];
            o_entry.item.v[i] = i_tdata[96 + 32*i +: 32];
            w_pm[i] = abs32(i_tdata[32*i +: 32]);
            o_entry.sq[i] = {32'd0, w_pm[i]} * {32'd0, w_pm[i]};
        end
        o_entry.item.dt  = w_dtp[35:8];
        o_entry.item.act = i_tuser[0];
    end

endmodule

// File: design/cgos_queue.sv
// short register queue between front and back ends
// no dependencies

module cgos_queue #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : AW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : AW'(r_rp + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (!i_push && i_pop) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/cgos_sqrt.sv
// pipelined integer square root, two radicand bits per stage
// no dependencies

module cgos_sqrt #(
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_n,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output logic [SW-1:0] o_sb
);
    localparam int STAGES = 32;

    logic          w_v    [0:STAGES];
    logic [33:0]   w_rem  [0:STAGES];
    logic [31:0]   w_root [0:STAGES];
    logic [63:0]   w_n    [0:STAGES];
    logic [SW-1:0] w_sb   [0:STAGES];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_n[0]    = i_n;
    assign w_sb[0]   = i_sb;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [35:0]   cur;
        logic [35:0]   trial;
        logic          take;
        logic          r_v;
        logic [33:0]   r_rem;
        logic [31:0]   r_root;
        logic [63:0]   r_n;
        logic [SW-1:0] r_sb;

        assign cur   = {w_rem[k], w_n[k][63:62]};
        assign trial = {2'b00, w_root[k], 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= take ? 34'(cur - trial) : cur[33:0];
                r_root <= {w_root[k][30:0], take};
                r_n    <= {w_n[k][61:0], 2'b00};
                r_sb   <= w_sb[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_n[k+1]    = r_n;
        assign w_sb[k+1]   = r_sb;
    end

    assign o_valid = w_v[STAGES];
    assign o_root  = w_root[STAGES];
    assign o_sb    = w_sb[STAGES];

endmodule

// File: design/cgos_div.sv
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
// no dependencies

module cgos_div #(
    parameter int NL = 1,
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NL-1:0][DW-1:0]  i_rem,
    input  logic [NL-1:0][QW-1:0]  i_low,
    input  logic [DW-1:0]          i_div,
    input  logic [SW-1:0]          i_sb,
    output logic                   o_valid,
    output logic [NL-1:0][QW-1:0]  o_q,
    output logic [SW-1:0]          o_sb
);
    logic                  w_v   [0:QW];
    logic [NL-1:0][DW-1:0] w_rem [0:QW];
    logic [NL-1:0][QW-1:0] w_lq  [0:QW];
    logic [DW-1:0]         w_div [0:QW];
    logic [SW-1:0]         w_sb  [0:QW];

    assign w_v[0]   = i_valid;
    assign w_rem[0] = i_rem;
    assign w_lq[0]  = i_low;
    assign w_div[0] = i_div;
    assign w_sb[0]  = i_sb;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NL-1:0][DW:0]   cur;
        logic [NL-1:0]         take;
        logic [NL-1:0][DW-1:0] n_rem;
        logic [NL-1:0][QW-1:0] n_lq;
        logic                  r_v;
        logic [NL-1:0][DW-1:0] r_rem;
        logic [NL-1:0][QW-1:0] r_lq;
        logic [DW-1:0]         r_div;
        logic [SW-1:0]         r_sb;

        // remainder shifts in the next dividend bit, quotient bit enters at the bottom
        always_comb begin
            for (int l = 0; l < NL; l++) begin
                cur[l]   = {w_rem[k][l], w_lq[k][l][QW-1]};
                take[l]  = (cur[l] >= {1'b0, w_div[k]});
                n_rem[l] = take[l] ? DW'(cur[l] - {1'b0, w_div[k]}) : cur[l][DW-1:0];
                n_lq[l]  = {w_lq[k][l][QW-2:0], take[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_lq  <= n_lq;
                r_div <= w_div[k];
                r_sb  <= w_sb[k];
            end
        end

        assign w_v[k+1]   = r_v;
        assign w_rem[k+1] = r_rem;
        assign w_lq[k+1]  = r_lq;
        assign w_div[k+1] = r_div;
        assign w_sb[k+1]  = r_sb;
    end

    assign o_valid = w_v[QW];
    assign o_q     = w_lq[QW];
    assign o_sb    = w_sb[QW];

endmodule

// File: design/cgos_back.sv
// back end: radius, acceleration and integration pipeline with output register
// depends on cgos_pkg, cgos_sqrt, cgos_div

module cgos_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cgos_pkg::t_cfg                 i_cfg,
    input  logic                           i_avail,
    input  cgos_pkg::t_qent                i_entry,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [cgos_pkg::M_TDATA_W-1:0] o_tdata
);
    import cgos_pkg::*;

    logic w_en;

    // stage 0: sum of squares
    logic        r0_v;
    logic [63:0] r0_r2;
    t_item       r0_item;

    // square root
    logic        s_v;
    logic [31:0] s_root;
    t_item       s_item;

    // clamp, r squared, saturation check
    logic [30:0] w_rmin;
    logic        r1_v;
    logic [31:0] r1_r;
    t_item       r1_item;
    logic        r2_v;
    logic [31:0] r2_r;
    logic [63:0] r2_d;
    t_item       r2_item;
    logic        r3_v;
    logic [31:0] r3_r;
    logic [63:0] r3_d;
    logic        r3_sat;
    t_item       r3_item;

    // acceleration magnitude
    logic [0:0][63:0] w_d1_rem;
    logic [0:0][31:0] w_d1_low;
    t_bk              w_d1_sbi;
    logic             d1_v;
    logic [0:0][31:0] d1_q;
    t_bk              d1_sb;

    // per-axis component
    logic [31:0]      w_amag;
    logic             r4_v;
    logic [2:0][63:0] r4_prod;
    logic [31:0]      r4_r;
    t_item            r4_item;
    logic [2:0][31:0] w_d2_rem;
    logic [2:0][31:0] w_d2_low;
    logic             d2_v;
    logic [2:0][31:0] d2_q;
    t_item            d2_item;

    // integration terms
    logic             r5_v;
    logic [2:0][59:0] r5_vm;
    logic [2:0][59:0] r5_am;
    t_item            r5_item;
    logic             r6_v;
    logic [2:0][43:0] r6_vdt;
    logic [2:0][43:0] r6_adt;
    logic [2:0][59:0] r6_lo;
    logic [2:0][39:0] r6_hi;
    t_item            r6_item;
    logic [2:0][71:0] w_hp;
    logic             r7_v;
    logic [2:0][43:0] r7_vdt;
    logic [2:0][46:0] r7_half;
    logic [2:0][31:0] r7_nv;
    t_item            r7_item;
    logic [2:0][31:0] w_np;

    logic                 r_out_v;
    logic [M_TDATA_W-1:0] r_out;

    assign w_en     = !r_out_v || i_tready;
    assign o_pop    = i_avail && w_en;
    assign o_tvalid = r_out_v;
    assign o_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r0_v    <= o_pop;
            r1_v    <= s_v;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= d1_v;
            r5_v    <= d2_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r_out_v <= r7_v;
        end
    end

    assign w_rmin = (i_cfg.rmin == '0) ? 31'd1 : i_cfg.rmin;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_r2   <= i_entry.sq[0] + i_entry.sq[1] + i_entry.sq[2];
            r0_item <= i_entry.item;

            r1_r    <= (s_root < {1'b0, w_rmin}) ? {1'b0, w_rmin} : s_root;
            r1_item <= s_item;

            r2_r    <= r1_r;
            r2_d    <= {32'd0, r1_r} * {32'd0, r1_r};
            r2_item <= r1_item;

            r3_r    <= r2_r;
            r3_d    <= r2_d;
            r3_sat  <= ({32'd0, i_cfg.gm} >= r2_d);
            r3_item <= r2_item;
        end
    end

    cgos_sqrt #(
        .SW ($bits(t_item))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_v),
        .i_n     (r0_r2),
        .i_sb    (r0_item),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_sb    (s_item)
    );

    // saturated case runs through the divider with a zero dividend and is replaced after
    assign w_d1_rem[0]  = r3_sat ? 64'd0 : {32'd0, i_cfg.gm};
    assign w_d1_low[0]  = 32'd0;
    assign w_d1_sbi.item = r3_item;
    assign w_d1_sbi.r    = r3_r;
    assign w_d1_sbi.sat  = r3_sat;

    cgos_div #(
        .NL (1),
        .DW (64),
        .QW (32),
        .SW ($bits(t_bk))
    ) u_div_accel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_rem   (w_d1_rem),
        .i_low   (w_d1_low),
        .i_div   (r3_d),
        .i_sb    (w_d1_sbi),
        .o_valid (d1_v),
        .o_q     (d1_q),
        .o_sb    (d1_sb)
    );

    assign w_amag = d1_sb.sat ? 32'hffff_ffff : d1_q[0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_prod[i] <= {32'd0, w_amag} * {32'd0, abs32(d1_sb.item.p[i])};
            end
            r4_r    <= d1_sb.r;
            r4_item <= d1_sb.item;
        end
    end

    // |p| never exceeds r, so each quotient fits in 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d2_rem[i] = r4_prod[i][63:32];
            w_d2_low[i] = r4_prod[i][31:0];
        end
    end

    cgos_div #(
        .NL (3),
        .DW (32),
        .QW (32),
        .SW ($bits(t_item))
    ) u_div_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_rem   (w_d2_rem),
        .i_low   (w_d2_low),
        .i_div   (r4_r),
        .i_sb    (r4_item),
        .o_valid (d2_v),
        .o_q     (d2_q),
        .o_sb    (d2_item)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_hp[i] = {12'd0, r6_lo[i]} + {r6_hi[i], 32'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_vm[i] <= {28'd0, abs32(d2_item.v[i])} * {32'd0, d2_item.dt};
                r5_am[i] <= {28'd0, d2_q[i]} * {32'd0, d2_item.dt};
            end
            r5_item <= d2_item;

            for (int i = 0; i < 3; i++) begin
                r6_vdt[i] <= r5_vm[i][59:16];
                r6_adt[i] <= r5_am[i][59:16];
                r6_lo[i]  <= {28'd0, r5_am[i][47:16]} * {32'd0, r5_item.dt};
                r6_hi[i]  <= {28'd0, r5_am[i][59:48]} * {12'd0, r5_item.dt};
            end
            r6_item <= r5_item;

            // acceleration points toward the origin: negative for a non-negative coordinate
            for (int i = 0; i < 3; i++) begin
                r7_vdt[i]  <= r6_vdt[i];
                r7_half[i] <= (w_hp[i][71:17] > {8'd0, TERM_CAP}) ? TERM_CAP : w_hp[i][63:17];
                r7_nv[i]   <= sat32($signed({{17{r6_item.v[i][31]}}, r6_item.v[i]})
                                    + smag(!r6_item.p[i][31], {3'd0, r6_adt[i]}));
            end
            r7_item <= r6_item;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_np[i] = sat32($signed({{17{r7_item.p[i][31]}}, r7_item.p[i]})
                            + smag(r7_item.v[i][31], {3'd0, r7_vdt[i]})
                            + smag(!r7_item.p[i][31], r7_half[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r7_item.act) begin
                r_out <= {r7_nv, w_np};
            end else begin
                r_out <= {r7_item.v, r7_item.p};
            end
        end
    end

endmodule

// File: design/central_gravity_orbit_step.sv
// top level of the point-mass gravity particle step
// depends on cgos_pkg, cgos_front, cgos_queue, cgos_back
//
// channel   dir  handshake              payload
// s         in   i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser
// m         out  o_m_tvalid/i_m_tready  o_m_tdata
// cfg       in   i_cfg_we               i_cfg_idx, i_cfg_wdata
//
// one request per cycle while m is not stalled; from acceptance to result a request passes
// through the 32-stage square root and the two 32-stage dividers in the back end
// reset is synchronous, active low, and restores the register defaults
// a stall on m freezes the back end; the front keeps accepting until the queue fills

module central_gravity_orbit_step #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, frame_time, zero pad
    input  logic [cgos_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // is_active
    input  logic [cgos_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [cgos_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [cgos_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cgos_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import cgos_pkg::*;

    t_cfg  r_cfg;
    t_qent w_entry;
    t_qent w_head;
    logic  w_full;
    logic  w_empty;
    logic  w_push;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gm     <= GM_RESET;
            r_cfg.tscale <= TSCALE_RESET;
            r_cfg.rmin   <= RMIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GM:     r_cfg.gm     <= i_cfg_wdata;
                CFG_TSCALE: r_cfg.tscale <= i_cfg_wdata[15:0];
                CFG_RMIN:   r_cfg.rmin   <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = !w_full;
    assign w_push     = i_s_tvalid && !w_full;

    cgos_front u_front (
        .i_tdata  (i_s_tdata),
        .i_tuser  (i_s_tuser),
        .i_tscale (r_cfg.tscale),
        .o_entry  (w_entry)
    );

    cgos_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     ($bits(t_qent))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    cgos_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_avail  (!w_empty),
        .i_entry  (w_head),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata)
    );

endmodule
